// ===== rtl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sustained threshold cascade package
// Shared types, field widths and codes for the threshold cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int WORD_REGS  = 4;
    localparam int WORD_IDX_W = 2;
    localparam int USAGE_W    = 32;
    localparam int TICK_W     = 24;
    localparam int ACTION_W   = 3;
    localparam int LEVEL_W    = 3;
    localparam int COUNT_W    = 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 59;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic [REG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_BASE  = 3'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_NONE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KILL = 3'd4;

    localparam logic signed [LEVEL_W-1:0] NO_LEVEL = -3'sd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TICK_W-1:0]   sustain;
        logic [USAGE_W-1:0]  threshold;
    } level_t;

    typedef struct packed {
        logic                  hit;
        logic [WORD_IDX_W-1:0] idx;
    } match_t;

endpackage : stc_pkg

`default_nettype wire

// ===== rtl/stc_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sample or clear request.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_sample_if
    import stc_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [USAGE_W-1:0] usage_kb;

    modport source (output valid, output cmd, output usage_kb, input ready);
    modport sink   (input valid, input cmd, input usage_kb, output ready);
endinterface : stc_sample_if

`default_nettype wire

// ===== rtl/stc_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one action and level result.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_result_if
    import stc_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action_code;
    logic signed [LEVEL_W-1:0]  active_level;

    modport source (output valid, output action_code, output active_level, input ready);
    modport sink   (input valid, input action_code, input active_level, output ready);
endinterface : stc_result_if

`default_nettype wire

// ===== rtl/stc_level_match.sv =====
// ----------------------------------------------------------------------------
// Level match
// Finds the highest enabled level whose threshold the usage meets.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_level_match
    import stc_pkg::*;
#(
    parameter int NUM_WORDS = 4
)(
    input  wire logic [COUNT_W-1:0] level_count,
    input  wire level_t             levels [NUM_WORDS],
    input  wire logic [USAGE_W-1:0] usage_kb,
    output match_t                  match
);

    logic [COUNT_W-1:0] eff_count;

    assign eff_count = (level_count > COUNT_W'(NUM_WORDS)) ? COUNT_W'(NUM_WORDS) : level_count;

    always_comb
    begin
        match = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if ((COUNT_W'(i) < eff_count) && (usage_kb >= levels[i].threshold))
            begin
                match.hit = 1'b1;
                match.idx = WORD_IDX_W'(i);
            end
        end
    end

endmodule : stc_level_match

`default_nettype wire

// ===== rtl/sustained_threshold_cascade.sv =====
// ----------------------------------------------------------------------------
// Sustained threshold cascade
// Tracks how long usage stays at a threshold level and emits the level's
// action once when it has been held for the configured number of ticks.
// ----------------------------------------------------------------------------
// A request goes from the input register through the match and counter
// update to the result register. Throughput: one request per cycle while
// the result channel is not stalled, set by that combinational step.
// Reset clears the tracking state, the pipeline valids and all configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sustained_threshold_cascade
    import stc_pkg::*;
#(
    parameter int LEVELS = 4
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    stc_sample_if.sink                 sample,
    stc_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_WORDS = (LEVELS < WORD_REGS) ? LEVELS : WORD_REGS;

    logic [COUNT_W-1:0]        level_count_reg;
    level_t                    level_reg [NUM_WORDS];

    logic                      in_valid_reg;
    logic                      in_cmd_reg;
    logic [USAGE_W-1:0]        in_usage_reg;

    logic                      trk_hit_reg;
    logic                      trk_hit_next;
    logic [WORD_IDX_W-1:0]     trk_idx_reg;
    logic [WORD_IDX_W-1:0]     trk_idx_next;
    logic [TICK_W-1:0]         tick_reg;
    logic [TICK_W-1:0]         tick_next;
    logic                      fired_reg;
    logic                      fired_next;

    logic                      out_valid_reg;
    logic [ACTION_W-1:0]       out_action_reg;
    logic [ACTION_W-1:0]       out_action_next;
    logic signed [LEVEL_W-1:0] out_level_reg;
    logic signed [LEVEL_W-1:0] out_level_next;

    match_t                    match;
    level_t                    sel_level;
    logic                      advance;
    logic                      changed;
    logic                      fired_keep;

    stc_level_match #(
        .NUM_WORDS (NUM_WORDS)
    ) u_match (
        .level_count (level_count_reg),
        .levels      (level_reg),
        .usage_kb    (in_usage_reg),
        .match       (match)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= '0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LEVEL_COUNT)
            begin
                level_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                if (cfg_index == REG_IDX_W'(int'(REG_LEVEL_BASE) + i))
                begin
                    level_reg[i] <= level_t'(cfg_data);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_cmd_reg   <= sample.cmd;
            in_usage_reg <= sample.usage_kb;
        end
    end

    always_comb
    begin
        sel_level = level_reg[0];
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (match.idx == WORD_IDX_W'(i))
            begin
                sel_level = level_reg[i];
            end
        end
    end

    always_comb
    begin
        changed         = (match.hit != trk_hit_reg) ||
                          (match.hit && (match.idx != trk_idx_reg));
        trk_hit_next    = match.hit;
        trk_idx_next    = match.idx;
        tick_next       = tick_reg;
        fired_keep      = fired_reg;
        fired_next      = fired_reg;
        out_action_next = ACT_NONE;
        out_level_next  = match.hit ? LEVEL_W'({1'b0, match.idx}) : NO_LEVEL;

        if (changed)
        begin
            tick_next  = TICK_W'(1);
            fired_keep = 1'b0;
        end
        else if (match.hit && (tick_reg != TICK_MAX))
        begin
            tick_next = tick_reg + TICK_W'(1);
        end

        fired_next = fired_keep;
        if (match.hit && !fired_keep && (tick_next >= sel_level.sustain))
        begin
            fired_next      = 1'b1;
            out_action_next = (sel_level.action > ACT_KILL) ? ACT_KILL : sel_level.action;
        end

        if (in_cmd_reg == CMD_CLEAR)
        begin
            trk_hit_next    = 1'b0;
            trk_idx_next    = '0;
            tick_next       = '0;
            fired_next      = 1'b0;
            out_action_next = ACT_NONE;
            out_level_next  = NO_LEVEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_hit_reg <= 1'b0;
            trk_idx_reg <= '0;
            tick_reg    <= '0;
            fired_reg   <= 1'b0;
        end
        else if (advance)
        begin
            trk_hit_reg <= trk_hit_next;
            trk_idx_reg <= trk_idx_next;
            tick_reg    <= tick_next;
            fired_reg   <= fired_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_action_reg <= out_action_next;
            out_level_reg  <= out_level_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.action_code  = out_action_reg;
    assign result.active_level = out_level_reg;

endmodule : sustained_threshold_cascade

`default_nettype wire
